>>> design/mmvq_pkg.sv
`timescale 1ns / 1ps

package mmvq_pkg;

    // Defaults for the top-level parameters.
    localparam int MMVQ_MAX_DIM      = 64;
    localparam int MMVQ_SAMPLE_WIDTH = 16;

    // Fixed field widths.
    localparam int CODE_WIDTH = 8;
    localparam int BITS_WIDTH = 4;
    localparam int STEP_WIDTH = $clog2(CODE_WIDTH);

    // Configuration reset and the point at which the level count is capped.
    localparam logic [BITS_WIDTH-1:0] BITS_RESET = 4'd8;
    localparam logic [BITS_WIDTH-1:0] BITS_CAP   = 4'd8;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ,
        ST_START,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

>>> design/mmvq_if.sv
`timescale 1ns / 1ps

interface mmvq_in_if #(
    parameter int SAMPLE_WIDTH = mmvq_pkg::MMVQ_SAMPLE_WIDTH
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] element_value;
    logic                           end_of_vector;

    modport source (output valid, output element_value, output end_of_vector, input ready);
    modport sink   (input valid, input element_value, input end_of_vector, output ready);
endinterface

interface mmvq_out_if #(
    parameter int SAMPLE_WIDTH = mmvq_pkg::MMVQ_SAMPLE_WIDTH
) ();
    logic                               valid;
    logic                               ready;
    logic [mmvq_pkg::CODE_WIDTH-1:0]    code;
    logic signed [SAMPLE_WIDTH-1:0]     vector_min;
    logic signed [SAMPLE_WIDTH-1:0]     vector_max;
    logic                               last_code;

    modport source (output valid, output code, output vector_min, output vector_max,
                    output last_code, input ready);
    modport sink   (input valid, input code, input vector_min, input vector_max,
                    input last_code, output ready);
endinterface

>>> design/minmax_vector_quantizer_core.sv
`timescale 1ns / 1ps

// Channel   Dir  Modport  Word
// i_elem    in   sink     element_value (signed), end_of_vector
// o_res     out  source   code, vector_min, vector_max, last_code
// i_cfg_*   in   -        bits_per_weight, written when i_cfg_we is high
//
// While the block is loading, an element word is taken whenever i_elem.valid is high.
// After the word that ends the vector, each code goes through a memory read,
// a setup state that starts the divider, the bit-serial divider itself, the
// state that takes its done pulse, and the output register that holds the code.
// Reset (i_rst_n, synchronous, active low) empties the vector and sets
// bits_per_weight to 8; the element memory itself is not cleared.
// While codes are being sent, i_elem.ready stays low; a stall on o_res holds
// the current code until it is taken.

module minmax_vector_quantizer_core #(
    parameter int MAX_DIM      = mmvq_pkg::MMVQ_MAX_DIM,
    parameter int SAMPLE_WIDTH = mmvq_pkg::MMVQ_SAMPLE_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    mmvq_in_if.sink                           i_elem,
    mmvq_out_if.source                        o_res,
    input  logic                              i_cfg_we,
    input  logic [mmvq_pkg::BITS_WIDTH-1:0]   i_cfg_wdata
);
    import mmvq_pkg::*;

    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW = $clog2(MAX_DIM + 1);
    localparam int NW = SAMPLE_WIDTH + CODE_WIDTH;

    t_state                         r_state;
    t_state                         n_state;
    logic [AW-1:0]                  r_idx;
    logic [AW-1:0]                  n_idx;
    logic [CODE_WIDTH-1:0]          r_code;
    logic [CODE_WIDTH-1:0]          n_code;
    logic [BITS_WIDTH-1:0]          r_bits;

    logic                           s_in_ready;
    logic                           s_in_accept;
    logic                           s_out_valid;
    logic                           s_last;
    logic                           s_clear;
    logic                           s_div_start;
    logic                           s_div_done;
    logic [CODE_WIDTH-1:0]          s_div_quo;

    logic signed [SAMPLE_WIDTH-1:0] s_rd_data;
    logic [CW-1:0]                  s_count;
    logic signed [SAMPLE_WIDTH-1:0] s_min;
    logic signed [SAMPLE_WIDTH-1:0] s_max;
    logic signed [SAMPLE_WIDTH:0]   s_off_full;
    logic signed [SAMPLE_WIDTH:0]   s_span_full;
    logic [SAMPLE_WIDTH-1:0]        s_off;
    logic [SAMPLE_WIDTH-1:0]        s_span;
    logic                           s_flat;
    logic [NW-1:0]                  s_num;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= BITS_RESET;
        end else if (i_cfg_we) begin
            r_bits <= i_cfg_wdata;
        end
    end

    mmvq_store #(
        .MAX_DIM      (MAX_DIM),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .AW           (AW),
        .CW           (CW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (s_in_accept),
        .i_wdata   (i_elem.element_value),
        .i_clear   (s_clear),
        .i_rd_addr (r_idx),
        .o_rd_data (s_rd_data),
        .o_count   (s_count),
        .o_min     (s_min),
        .o_max     (s_max)
    );

    // Offset and span are never negative, so their low bits hold them unsigned.
    assign s_off_full  = {s_rd_data[SAMPLE_WIDTH-1], s_rd_data} - {s_min[SAMPLE_WIDTH-1], s_min};
    assign s_span_full = {s_max[SAMPLE_WIDTH-1], s_max} - {s_min[SAMPLE_WIDTH-1], s_min};
    assign s_off       = s_off_full[SAMPLE_WIDTH-1:0];
    assign s_span      = s_span_full[SAMPLE_WIDTH-1:0];
    assign s_flat      = (s_span == '0);

    // The product levels * offset needs no multiplier: levels is a power of
    // two below the cap, and at or above the cap 255 * x is (x << 8) - x.
    always_comb begin
        if (r_bits >= BITS_CAP) begin
            s_num = {s_off, {CODE_WIDTH{1'b0}}} - NW'(s_off);
        end else begin
            s_num = NW'(s_off) << r_bits[STEP_WIDTH-1:0];
        end
    end

    mmvq_div #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_div_start),
        .i_num   (s_num),
        .i_den   (s_span),
        .o_done  (s_div_done),
        .o_quo   (s_div_quo)
    );

    assign s_in_accept = i_elem.valid && s_in_ready;
    assign s_last      = (CW'(r_idx) + CW'(1) == s_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
    end

    // Loading takes one word per cycle. Once the last word is in, the stored
    // elements are read back in order and each one goes through the divider.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_code      = r_code;
        s_in_ready  = 1'b0;
        s_out_valid = 1'b0;
        s_div_start = 1'b0;
        s_clear     = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                s_in_ready = 1'b1;
                if (i_elem.valid && i_elem.end_of_vector) begin
                    n_idx   = '0;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_START;
            end
            ST_START: begin
                s_div_start = 1'b1;
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                if (s_div_done) begin
                    // A flat vector has no span to divide by; all codes are zero.
                    n_code  = s_flat ? '0 : s_div_quo;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                s_out_valid = 1'b1;
                if (o_res.ready) begin
                    if (s_last) begin
                        s_clear = 1'b1;
                        n_state = ST_LOAD;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    assign i_elem.ready     = s_in_ready;
    assign o_res.valid      = s_out_valid;
    assign o_res.code       = r_code;
    assign o_res.vector_min = s_min;
    assign o_res.vector_max = s_max;
    assign o_res.last_code  = s_last;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_in_ready && s_out_valid))
        else $error("input accepted while a code is pending");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_out_valid |-> (s_min <= s_max))
        else $error("vector minimum above maximum during output");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside of its state");

    a_flat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_out_valid && s_flat) |-> (r_code == '0))
        else $error("nonzero code for a flat vector");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_out_valid && o_res.ready && s_last) |=> (s_count == '0))
        else $error("vector not emptied after its last code");
`endif

endmodule

>>> design/mmvq_store.sv
`timescale 1ns / 1ps

module mmvq_store #(
    parameter int MAX_DIM      = mmvq_pkg::MMVQ_MAX_DIM,
    parameter int SAMPLE_WIDTH = mmvq_pkg::MMVQ_SAMPLE_WIDTH,
    parameter int AW           = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
    parameter int CW           = $clog2(MAX_DIM + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr,
    input  logic signed [SAMPLE_WIDTH-1:0] i_wdata,
    input  logic                           i_clear,
    input  logic [AW-1:0]                  i_rd_addr,
    output logic signed [SAMPLE_WIDTH-1:0] o_rd_data,
    output logic [CW-1:0]                  o_count,
    output logic signed [SAMPLE_WIDTH-1:0] o_min,
    output logic signed [SAMPLE_WIDTH-1:0] o_max
);
    import mmvq_pkg::*;

    localparam logic signed [SAMPLE_WIDTH-1:0] MAX_POS = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] MAX_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic signed [SAMPLE_WIDTH-1:0] r_mem [MAX_DIM];
    logic signed [SAMPLE_WIDTH-1:0] r_rd_data;
    logic [CW-1:0]                  r_count;
    logic signed [SAMPLE_WIDTH-1:0] r_min;
    logic signed [SAMPLE_WIDTH-1:0] r_max;
    logic                           s_store;

    // Elements beyond the capacity are dropped and leave min and max alone.
    assign s_store = i_wr && (r_count < CW'(MAX_DIM));

    always_ff @(posedge i_clk) begin
        if (s_store) begin
            r_mem[r_count[AW-1:0]] <= i_wdata;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_count <= '0;
            r_min   <= MAX_POS;
            r_max   <= MAX_NEG;
        end else if (s_store) begin
            r_count <= r_count + CW'(1);
            if (i_wdata < r_min) begin
                r_min <= i_wdata;
            end
            if (i_wdata > r_max) begin
                r_max <= i_wdata;
            end
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_count   = r_count;
    assign o_min     = r_min;
    assign o_max     = r_max;

endmodule

>>> design/mmvq_div.sv
`timescale 1ns / 1ps

module mmvq_div #(
    parameter int SAMPLE_WIDTH = mmvq_pkg::MMVQ_SAMPLE_WIDTH
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_start,
    input  logic [SAMPLE_WIDTH+mmvq_pkg::CODE_WIDTH-1:0] i_num,
    input  logic [SAMPLE_WIDTH-1:0]                      i_den,
    output logic                                         o_done,
    output logic [mmvq_pkg::CODE_WIDTH-1:0]              o_quo
);
    import mmvq_pkg::*;

    localparam int NW = SAMPLE_WIDTH + CODE_WIDTH;
    localparam logic [STEP_WIDTH-1:0] STEP_LAST = STEP_WIDTH'(CODE_WIDTH - 1);

    logic [NW-1:0]         r_rem;
    logic [NW-1:0]         r_den;
    logic [CODE_WIDTH-1:0] r_quo;
    logic [STEP_WIDTH-1:0] r_step;
    logic                  r_busy;
    logic                  r_done;
    logic                  s_ge;
    logic [NW-1:0]         s_diff;

    // Restoring division, one quotient bit per cycle, most significant first.
    // The quotient never exceeds the code range, so the divisor starts
    // shifted up by one less than the code width.
    assign s_ge   = (r_rem >= r_den);
    assign s_diff = r_rem - r_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            // Done pulses for one cycle after the final quotient bit.
            r_done <= !i_start && r_busy && (r_step == STEP_LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == STEP_LAST) begin
                    r_busy <= 1'b0;
                end
                r_step <= r_step + STEP_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= NW'(i_den) << (CODE_WIDTH - 1);
            r_quo <= '0;
        end else if (r_busy) begin
            if (s_ge) begin
                r_rem <= s_diff;
            end
            r_den <= r_den >> 1;
            r_quo <= {r_quo[CODE_WIDTH-2:0], s_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
